// ----- rtl/tbc_pkg.sv -----
`default_nettype none
package tbc_pkg;

  localparam int POINT_BITS     = 16;
  localparam int WEIGHT_BITS    = 16;
  localparam int VERTEX_BITS    = 48;
  localparam int CFG_INDEX_BITS = 2;
  localparam int QUOT_BITS      = 16;

  // register stages of the triple-product section and of the divider
  localparam int TRI_LAT = 6;
  localparam int DIV_LAT = QUOT_BITS + 2;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_VERTEX_ZERO  = 2'd0,
    REG_VERTEX_ONE   = 2'd1,
    REG_VERTEX_TWO   = 2'd2,
    REG_VERTEX_THREE = 2'd3
  } cfg_reg_t;

  typedef logic        [VERTEX_BITS-1:0] vertex_t;
  typedef logic signed [POINT_BITS-1:0]  point_t;
  typedef logic signed [WEIGHT_BITS-1:0] weight_t;

  localparam weight_t WEIGHT_MAX = 16'sh7fff;
  localparam weight_t WEIGHT_MIN = 16'sh8000;
  localparam logic [QUOT_BITS-1:0] POS_LIMIT = 16'h7fff;
  localparam logic [QUOT_BITS-1:0] NEG_LIMIT = 16'h8000;

  typedef struct packed {
    logic [QUOT_BITS-1:0] q;
    logic                 neg;
    logic                 sat;
  } quot_t;

  typedef struct packed {
    weight_t weight_zero;
    weight_t weight_one;
    weight_t weight_two;
    weight_t weight_three;
    logic    degenerate;
    logic    clipped;
  } result_t;

  // width of the signed triple products and of the derived first numerator
  function automatic int num_bits(input int coord_bits);
    return 3 * coord_bits + 8;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/tbc_if.sv -----
`default_nettype none
interface tbc_point_if;
  import tbc_pkg::*;
  logic   valid;
  logic   ready;
  point_t point_x;
  point_t point_y;
  point_t point_z;
  modport source (output valid, output point_x, output point_y, output point_z, input ready);
  modport sink (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

interface tbc_weight_if;
  import tbc_pkg::*;
  logic    valid;
  logic    ready;
  weight_t weight_zero;
  weight_t weight_one;
  weight_t weight_two;
  weight_t weight_three;
  logic    degenerate;
  logic    clipped;
  modport source (output valid, output weight_zero, output weight_one, output weight_two,
                  output weight_three, output degenerate, output clipped, input ready);
  modport sink (input valid, input weight_zero, input weight_one, input weight_two,
                input weight_three, input degenerate, input clipped, output ready);
endinterface
`default_nettype wire

// ----- rtl/tbc_triple.sv -----
`default_nettype none
module tbc_triple #(
  parameter int COORD_BITS = 16
) (
  input  logic                                              clk,
  input  logic                                              en,
  input  tbc_pkg::vertex_t                                  vertex [4],
  input  tbc_pkg::point_t                                   point_x,
  input  tbc_pkg::point_t                                   point_y,
  input  tbc_pkg::point_t                                   point_z,
  output logic signed [tbc_pkg::num_bits(COORD_BITS)-1:0]   den_o,
  output logic signed [tbc_pkg::num_bits(COORD_BITS)-1:0]   num_o [4]
);
  import tbc_pkg::*;

  localparam int DW  = COORD_BITS + 1;
  localparam int PRW = 2 * DW;
  localparam int XW  = 2 * DW + 1;
  localparam int MW  = DW + XW;
  localparam int TW  = MW + 2;
  localparam int NW  = num_bits(COORD_BITS);
  localparam int PEW = (COORD_BITS > POINT_BITS) ? COORD_BITS : POINT_BITS;
  localparam int VEW = (3 * COORD_BITS > VERTEX_BITS) ? 3 * COORD_BITS : VERTEX_BITS;

  localparam int NX1 [3] = '{1, 2, 0};
  localparam int NX2 [3] = '{2, 0, 1};

  typedef logic signed [DW-1:0]  diff_t;
  typedef logic signed [PRW-1:0] prod_t;
  typedef logic signed [XW-1:0]  cross_t;
  typedef logic signed [MW-1:0]  mprod_t;
  typedef logic signed [TW-1:0]  sum_t;
  typedef logic signed [NW-1:0]  num_t;

  function automatic diff_t vcoord(input vertex_t v, input int k);
    logic [VEW-1:0]        ext;
    logic [COORD_BITS-1:0] f;
    ext = VEW'(v);
    f   = ext[k*COORD_BITS +: COORD_BITS];
    return {f[COORD_BITS-1], f};
  endfunction

  function automatic diff_t pcoord(input point_t p);
    logic [PEW-1:0]        ext;
    logic [COORD_BITS-1:0] f;
    ext = PEW'($unsigned(p));
    f   = ext[COORD_BITS-1:0];
    return {f[COORD_BITS-1], f};
  endfunction

  point_t pt [3];
  assign pt[0] = point_x;
  assign pt[1] = point_y;
  assign pt[2] = point_z;

  // stage 1: edge vectors from vertex zero
  diff_t a1_r [3];
  diff_t a2_r [3];
  diff_t a3_r [3];
  diff_t e_r  [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        a1_r[k] <= vcoord(vertex[1], k) - vcoord(vertex[0], k);
        a2_r[k] <= vcoord(vertex[2], k) - vcoord(vertex[0], k);
        a3_r[k] <= vcoord(vertex[3], k) - vcoord(vertex[0], k);
        e_r[k]  <= pcoord(pt[k]) - vcoord(vertex[0], k);
      end
    end
  end

  // stage 2: partial products of a2 x a3, e x a3 and a2 x e
  diff_t opu [3][3];
  diff_t opv [3][3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      opu[0][k] = a2_r[k];
      opv[0][k] = a3_r[k];
      opu[1][k] = e_r[k];
      opv[1][k] = a3_r[k];
      opu[2][k] = a2_r[k];
      opv[2][k] = e_r[k];
    end
  end

  prod_t pp_r [3][3][2];
  diff_t a1_2_r [3];
  diff_t e_2_r  [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < 3; k++) begin
          pp_r[c][k][0] <= prod_t'(opu[c][NX1[k]]) * prod_t'(opv[c][NX2[k]]);
          pp_r[c][k][1] <= prod_t'(opu[c][NX2[k]]) * prod_t'(opv[c][NX1[k]]);
        end
      end
      a1_2_r <= a1_r;
      e_2_r  <= e_r;
    end
  end

  // stage 3: cross products
  cross_t cr_r [3][3];
  diff_t  a1_3_r [3];
  diff_t  e_3_r  [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < 3; k++) begin
          cr_r[c][k] <= cross_t'(pp_r[c][k][0]) - cross_t'(pp_r[c][k][1]);
        end
      end
      a1_3_r <= a1_2_r;
      e_3_r  <= e_2_r;
    end
  end

  // stage 4: dot-product terms for volume, n1, n2, n3
  diff_t  lhs [4][3];
  cross_t rhs [4][3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lhs[0][k] = a1_3_r[k];
      rhs[0][k] = cr_r[0][k];
      lhs[1][k] = e_3_r[k];
      rhs[1][k] = cr_r[0][k];
      lhs[2][k] = a1_3_r[k];
      rhs[2][k] = cr_r[1][k];
      lhs[3][k] = a1_3_r[k];
      rhs[3][k] = cr_r[2][k];
    end
  end

  mprod_t mp_r [4][3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int t = 0; t < 4; t++) begin
        for (int k = 0; k < 3; k++) begin
          mp_r[t][k] <= mprod_t'(lhs[t][k]) * mprod_t'(rhs[t][k]);
        end
      end
    end
  end

  // stage 5: sum the dot-product terms
  sum_t sum_r [4];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int t = 0; t < 4; t++) begin
        sum_r[t] <= sum_t'(mp_r[t][0]) + sum_t'(mp_r[t][1]) + sum_t'(mp_r[t][2]);
      end
    end
  end

  // stage 6: weight zero takes what is left of the volume
  num_t den_r;
  num_t num_r [4];

  always_ff @(posedge clk) begin
    if (en) begin
      den_r    <= num_t'(sum_r[0]);
      num_r[0] <= num_t'(sum_r[0]) - num_t'(sum_r[1]) - num_t'(sum_r[2]) - num_t'(sum_r[3]);
      num_r[1] <= num_t'(sum_r[1]);
      num_r[2] <= num_t'(sum_r[2]);
      num_r[3] <= num_t'(sum_r[3]);
    end
  end

  assign den_o = den_r;
  assign num_o = num_r;

endmodule
`default_nettype wire

// ----- rtl/tbc_divider.sv -----
`default_nettype none
module tbc_divider #(
  parameter int NUM_BITS  = 56,
  parameter int FRAC_BITS = 14
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [NUM_BITS-1:0] num,
  input  logic signed [NUM_BITS-1:0] den,
  output tbc_pkg::quot_t             quot
);
  import tbc_pkg::*;

  localparam int SH = (FRAC_BITS > QUOT_BITS) ? FRAC_BITS : QUOT_BITS;
  localparam int CW = NUM_BITS + SH + 1;

  // stage 0: magnitudes and result sign
  logic [NUM_BITS-1:0] mag_num_r;
  logic [NUM_BITS-1:0] mag_den_r;
  logic                neg0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      neg0_r    <= num[NUM_BITS-1] ^ den[NUM_BITS-1];
      mag_num_r <= num[NUM_BITS-1] ? $unsigned(-num) : $unsigned(num);
      mag_den_r <= den[NUM_BITS-1] ? $unsigned(-den) : $unsigned(den);
    end
  end

  // stage 1: scale the numerator, flag quotients that need more than QUOT_BITS
  logic [CW-1:0] n_sh;
  logic [CW-1:0] d_sh;
  assign n_sh = CW'(mag_num_r) << FRAC_BITS;
  assign d_sh = CW'(mag_den_r) << QUOT_BITS;

  logic [CW-1:0]        rem_r [QUOT_BITS];
  logic [NUM_BITS-1:0]  dsr_r [QUOT_BITS];
  logic [QUOT_BITS-1:0] q_r   [QUOT_BITS+1];
  logic                 neg_r [QUOT_BITS+1];
  logic                 sat_r [QUOT_BITS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= n_sh;
      dsr_r[0] <= mag_den_r;
      q_r[0]   <= '0;
      neg_r[0] <= neg0_r;
      sat_r[0] <= n_sh >= d_sh;
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar s = 0; s < QUOT_BITS; s++) begin : g_step
    localparam int B = QUOT_BITS - 1 - s;
    logic [CW-1:0] trial;
    logic          ge;
    assign trial = CW'(dsr_r[s]) << B;
    assign ge    = rem_r[s] >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[s+1]   <= q_r[s] | (QUOT_BITS'(ge) << B);
        neg_r[s+1] <= neg_r[s];
        sat_r[s+1] <= sat_r[s];
      end
    end

    if (s < QUOT_BITS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s+1] <= ge ? rem_r[s] - trial : rem_r[s];
          dsr_r[s+1] <= dsr_r[s];
        end
      end
    end
  end

  assign quot = '{q: q_r[QUOT_BITS], neg: neg_r[QUOT_BITS], sat: sat_r[QUOT_BITS]};

endmodule
`default_nettype wire

// ----- rtl/tetra_barycentric_coords_core.sv -----
`default_nettype none
// channel | direction | payload                                  | handshake
// in_if   | sink      | point_x, point_y, point_z                | valid / ready
// out_if  | source    | weight_zero..three, degenerate, clipped  | valid / ready
// cfg     | write     | cfg_index, cfg_data                      | cfg_we
//
// One request per cycle while in_if.ready is high; a taken request passes through
// 25 register stages (6 triple-product, 18 divider, output register) before it shows on out_if.
// Each weight has its own divider that resolves one quotient bit per stage.
// Reset is synchronous: it clears the vertices, the pipeline valid bits and the output and skid valid bits.
// A full skid slot freezes the whole pipeline and drops in_if.ready; nothing is lost.
module tetra_barycentric_coords_core #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [tbc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  tbc_pkg::vertex_t                      cfg_data,
  tbc_point_if.sink                             in_if,
  tbc_weight_if.source                          out_if
);
  import tbc_pkg::*;

  localparam int NW       = num_bits(COORD_BITS);
  localparam int PIPE_LAT = TRI_LAT + DIV_LAT;

  vertex_t vertex_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) vertex_r[i] <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_VERTEX_ZERO:  vertex_r[0] <= cfg_data;
        REG_VERTEX_ONE:   vertex_r[1] <= cfg_data;
        REG_VERTEX_TWO:   vertex_r[2] <= cfg_data;
        REG_VERTEX_THREE: vertex_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  logic out_valid_r;
  logic skid_valid_r;
  logic take;
  logic push;

  // advance the pipeline whenever the skid slot is free
  assign en          = !skid_valid_r;
  assign in_if.ready = en;
  assign take        = out_valid_r && out_if.ready;

  logic vld_r [PIPE_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIPE_LAT; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_if.valid;
      for (int i = 1; i < PIPE_LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  assign push = en && vld_r[PIPE_LAT-1];

  logic signed [NW-1:0] den_w;
  logic signed [NW-1:0] num_w [4];

  tbc_triple #(.COORD_BITS(COORD_BITS)) u_triple (
    .clk     (clk),
    .en      (en),
    .vertex  (vertex_r),
    .point_x (in_if.point_x),
    .point_y (in_if.point_y),
    .point_z (in_if.point_z),
    .den_o   (den_w),
    .num_o   (num_w)
  );

  quot_t quot_w [4];

  for (genvar i = 0; i < 4; i++) begin : g_div
    tbc_divider #(.NUM_BITS(NW), .FRAC_BITS(FRAC_BITS)) u_div (
      .clk  (clk),
      .en   (en),
      .num  (num_w[i]),
      .den  (den_w),
      .quot (quot_w[i])
    );
  end

  // carry the zero-volume flag alongside the dividers
  logic deg_r [DIV_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      deg_r[0] <= (den_w == '0);
      for (int i = 1; i < DIV_LAT; i++) deg_r[i] <= deg_r[i-1];
    end
  end

  weight_t wt [4];
  logic    clip_any;
  result_t res_w;

  always_comb begin
    clip_any = 1'b0;
    for (int i = 0; i < 4; i++) begin
      wt[i] = '0;
      if (quot_w[i].sat || quot_w[i].q != '0) begin
        if (quot_w[i].neg) begin
          if (quot_w[i].sat || quot_w[i].q > NEG_LIMIT) begin
            wt[i]    = WEIGHT_MIN;
            clip_any = 1'b1;
          end else begin
            wt[i] = weight_t'(QUOT_BITS'(0) - quot_w[i].q);
          end
        end else begin
          if (quot_w[i].sat || quot_w[i].q > POS_LIMIT) begin
            wt[i]    = WEIGHT_MAX;
            clip_any = 1'b1;
          end else begin
            wt[i] = weight_t'(quot_w[i].q);
          end
        end
      end
    end
    if (deg_r[DIV_LAT-1]) begin
      res_w = '{weight_zero: '0, weight_one: '0, weight_two: '0, weight_three: '0,
                degenerate: 1'b1, clipped: 1'b0};
    end else begin
      res_w = '{weight_zero: wt[0], weight_one: wt[1], weight_two: wt[2],
                weight_three: wt[3], degenerate: 1'b0, clipped: clip_any};
    end
  end

  result_t out_r;
  result_t skid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take) skid_valid_r <= 1'b0;
    end else if (push) begin
      if (!out_valid_r || take) out_valid_r <= 1'b1;
      else skid_valid_r <= 1'b1;
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take) out_r <= skid_r;
    end else if (push) begin
      if (!out_valid_r || take) out_r <= res_w;
      else skid_r <= res_w;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.weight_zero  = out_r.weight_zero;
  assign out_if.weight_one   = out_r.weight_one;
  assign out_if.weight_two   = out_r.weight_two;
  assign out_if.weight_three = out_r.weight_three;
  assign out_if.degenerate   = out_r.degenerate;
  assign out_if.clipped      = out_r.clipped;

endmodule
`default_nettype wire

// ----- rtl/tbc_checker.sv -----
`default_nettype none
module tbc_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input tbc_pkg::weight_t       weight_zero,
  input tbc_pkg::weight_t       weight_one,
  input tbc_pkg::weight_t       weight_two,
  input tbc_pkg::weight_t       weight_three,
  input logic                   degenerate,
  input logic                   clipped
);
  import tbc_pkg::*;

  // a flat tetrahedron gives zero weights and no clip
  a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && degenerate |-> weight_zero == '0 && weight_one == '0 &&
      weight_two == '0 && weight_three == '0 && !clipped)
    else $error("degenerate result with nonzero weights or clip");

  // a clip leaves at least one weight at a rail
  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && clipped |->
      weight_zero == WEIGHT_MAX || weight_zero == WEIGHT_MIN ||
      weight_one == WEIGHT_MAX || weight_one == WEIGHT_MIN ||
      weight_two == WEIGHT_MAX || weight_two == WEIGHT_MIN ||
      weight_three == WEIGHT_MAX || weight_three == WEIGHT_MIN)
    else $error("clipped set with no saturated weight");

  // input backpressure only follows a stalled result
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> $past(out_valid && !out_ready))
    else $error("input stalled without output backpressure");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(weight_zero) &&
      $stable(weight_one) && $stable(weight_two) && $stable(weight_three) &&
      $stable(degenerate) && $stable(clipped))
    else $error("stalled result changed");

endmodule

bind tetra_barycentric_coords_core tbc_checker u_tbc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_if.ready),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .weight_zero  (out_if.weight_zero),
  .weight_one   (out_if.weight_one),
  .weight_two   (out_if.weight_two),
  .weight_three (out_if.weight_three),
  .degenerate   (out_if.degenerate),
  .clipped      (out_if.clipped)
);
`default_nettype wire
